>>> rtl/mandelbrot_tile_pixel_core_macros.svh
// Assertion macros shared by the tile pixel core modules.
`ifndef MANDELBROT_TILE_PIXEL_CORE_MACROS_SVH
`define MANDELBROT_TILE_PIXEL_CORE_MACROS_SVH
`ifndef SYNTH
`define MTP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);
`define MTP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);
`else
`define MTP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg)
`define MTP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

>>> rtl/mtp_pkg.sv
// Constants, widths and controller/datapath interface types of the tile pixel core.
package mtp_pkg;

  localparam int FRAC_BITS = 55;
  localparam int MAX_STEPS = 256;
  localparam int TILE_SIZE = 256;
  localparam int TILE_LOG2 = $clog2(TILE_SIZE);

  localparam int WORD_W = 64;
  localparam int HALF_W = WORD_W / 2;
  localparam int ACC_W  = 2 * WORD_W;

  localparam int ZOOM_W  = 6;
  localparam int TILE_W  = 40;
  localparam int PIX_W   = 8;
  localparam int CHAN_W  = 8;
  localparam int STEPS_W = 9;

  localparam int POS_W    = TILE_W + TILE_LOG2 + 1;
  localparam int UP_SH    = FRAC_BITS + 1 - TILE_LOG2;
  localparam int WIDE_W   = POS_W + UP_SH;
  localparam int SCALED_W = FRAC_BITS + 3;
  localparam int K_W      = $clog2(MAX_STEPS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = TILE_W;
  localparam int IN_DATA_W  = 2 * PIX_W;
  localparam int OUT_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_Y = 2'd2;

  localparam logic [SCALED_W-1:0] SCALED_LIM = SCALED_W'(11) << (FRAC_BITS - 1);
  localparam logic [WORD_W-1:0] ONE_FX    = WORD_W'(1) << FRAC_BITS;
  localparam logic [WORD_W-1:0] FOUR_FX   = WORD_W'(4) << FRAC_BITS;
  localparam logic [WORD_W-1:0] OFFSET_RE = WORD_W'(3) << (FRAC_BITS - 1);
  localparam logic [WORD_W-1:0] OFFSET_IM = ONE_FX;
  localparam logic [WORD_W-1:0] FX_MAX    = {1'b0, {(WORD_W - 1){1'b1}}};

  typedef struct packed {
    logic latch_pix;
    logic scale;
    logic offset;
    logic start_sq;
    logic cap_sq;
    logic start_p;
    logic update_z;
    logic check;
    logic load_out;
  } mtp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic escape;
    logic k_zero;
    logic k_last;
    logic out_free;
  } mtp_status_t;

endpackage

>>> rtl/mandelbrot_tile_pixel_core.sv
// Top level of the escape-time Mandelbrot tile pixel core with HSV coloring.
//
// One pixel position (column, row) goes in, one color comes out. Zoom and tile
// position are set through the configuration channel; the user must do so only
// while the core is idle; the core does not enforce this. The core works on
// one pixel at a time, running 1 to 256 escape-time steps on it, and the time
// per pixel is set by the step loop: each step runs one 64-bit fixed-point
// product and then two squares, and each product is assembled from four 32x32
// partial products in one of two multiplier units. A finished pixel waits in
// the output register, so the next pixel is accepted while the result is not
// yet taken.
module mandelbrot_tile_pixel_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // s_tdata: pixel_col [7:0], pixel_row [15:8]
  input  logic [mtp_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // m_tdata: red [7:0], green [15:8], blue [23:16], steps_used [32:24], zero pad
  output logic [mtp_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser: inside_set [0]
  output logic                           m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtp_pkg::CFG_DATA_W-1:0] cfg_data
);

  mtp_pkg::mtp_cmd_t    cmd;
  mtp_pkg::mtp_status_t status;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;

  mtp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .status  (status),
    .cmd     (cmd)
  );

  mtp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_data    (s_tdata),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_ready   (m_tready),
    .m_valid   (m_tvalid),
    .m_data    (m_tdata),
    .m_user    (m_tuser)
  );

endmodule

>>> rtl/mtp_fxmul.sv
// Multi-cycle signed fixed-point multiplier built on one 32x32 partial-product multiplier.
`include "mandelbrot_tile_pixel_core_macros.svh"

module mtp_fxmul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [mtp_pkg::WORD_W-1:0] a,
  input  logic [mtp_pkg::WORD_W-1:0] b,
  output logic                       done,
  output logic [mtp_pkg::WORD_W-1:0] result
);

  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_LAST_PP = 3'd3;
  localparam logic [PH_W-1:0] PH_FINAL   = 3'd5;

  logic                           busy;
  logic                           pp_vld;
  logic [PH_W-1:0]                ph;
  logic                           neg;
  logic [mtp_pkg::WORD_W-1:0]     ua;
  logic [mtp_pkg::WORD_W-1:0]     ub;
  logic [2*mtp_pkg::HALF_W-1:0]   pp;
  logic [1:0]                     pp_sh;
  logic [mtp_pkg::ACC_W-1:0]      acc;

  logic [mtp_pkg::HALF_W-1:0]     a_half;
  logic [mtp_pkg::HALF_W-1:0]     b_half;
  logic [mtp_pkg::WORD_W-1:0]     q;
  logic [mtp_pkg::WORD_W-1:0]     qs;
  logic                           sat;
  logic                           frac;
  logic [mtp_pkg::WORD_W-1:0]     res_next;

  // Partial products in the order lo*lo, lo*hi, hi*lo, hi*hi.
  assign a_half = ph[1] ? ua[mtp_pkg::WORD_W-1:mtp_pkg::HALF_W] : ua[mtp_pkg::HALF_W-1:0];
  assign b_half = ph[0] ? ub[mtp_pkg::WORD_W-1:mtp_pkg::HALF_W] : ub[mtp_pkg::HALF_W-1:0];

  always_comb begin
    q    = acc[mtp_pkg::FRAC_BITS +: mtp_pkg::WORD_W];
    sat  = (|acc[mtp_pkg::ACC_W-1:mtp_pkg::WORD_W+mtp_pkg::FRAC_BITS]) ||
           (q > (mtp_pkg::FX_MAX - mtp_pkg::WORD_W'(1)));
    frac = |acc[mtp_pkg::FRAC_BITS-1:0];
    qs   = sat ? mtp_pkg::FX_MAX : q;
    // A negative product rounds toward minus infinity: -(q+1) is simply ~q.
    if (!neg) begin
      res_next = qs;
    end else if (frac && !sat) begin
      res_next = ~qs;
    end else begin
      res_next = mtp_pkg::WORD_W'(0) - qs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pp_vld <= 1'b0;
      ph     <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        ph     <= '0;
        pp_vld <= 1'b0;
      end else if (busy) begin
        pp_vld <= (ph <= PH_LAST_PP);
        if (ph == PH_FINAL) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          ph <= ph + PH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= a[mtp_pkg::WORD_W-1] ? mtp_pkg::WORD_W'(0) - a : a;
      ub  <= b[mtp_pkg::WORD_W-1] ? mtp_pkg::WORD_W'(0) - b : b;
      neg <= a[mtp_pkg::WORD_W-1] ^ b[mtp_pkg::WORD_W-1];
      acc <= '0;
    end else begin
      if (busy && (ph <= PH_LAST_PP)) begin
        pp    <= a_half * b_half;
        pp_sh <= {1'b0, ph[1]} + {1'b0, ph[0]};
      end
      if (pp_vld) begin
        acc <= acc + (mtp_pkg::ACC_W'(pp) << (mtp_pkg::HALF_W * pp_sh));
      end
      if (busy && (ph == PH_FINAL)) begin
        result <= res_next;
      end
    end
  end

  `MTP_ASSERT_IMP(a_no_restart, clk, rst, start, !busy, "multiplier restarted while busy")

endmodule

>>> rtl/mtp_datapath.sv
// Datapath of the tile pixel core: configuration, coordinates, iteration, color, output.
`include "mandelbrot_tile_pixel_core_macros.svh"

module mtp_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  mtp_pkg::mtp_cmd_t              cmd,
  output mtp_pkg::mtp_status_t           status,
  input  logic [mtp_pkg::IN_DATA_W-1:0]  s_data,
  input  logic                           cfg_we,
  input  logic [mtp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           m_ready,
  output logic                           m_valid,
  output logic [mtp_pkg::OUT_DATA_W-1:0] m_data,
  output logic                           m_user
);

  localparam int PAD_W = mtp_pkg::OUT_DATA_W - 3 * mtp_pkg::CHAN_W - mtp_pkg::STEPS_W;
  localparam int RGB_W = 3 * mtp_pkg::CHAN_W;

  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;

  localparam logic [mtp_pkg::CHAN_W-1:0] CH_FULL = '1;
  localparam logic [mtp_pkg::CHAN_W-1:0] CH_ZERO = '0;

  logic [mtp_pkg::ZOOM_W-1:0]   zoom;
  logic [mtp_pkg::TILE_W-1:0]   tile_x;
  logic [mtp_pkg::TILE_W-1:0]   tile_y;
  logic [mtp_pkg::PIX_W-1:0]    pix_col;
  logic [mtp_pkg::PIX_W-1:0]    pix_row;
  logic [mtp_pkg::SCALED_W-1:0] s_re;
  logic [mtp_pkg::SCALED_W-1:0] s_im;
  logic [mtp_pkg::WORD_W-1:0]   cr;
  logic [mtp_pkg::WORD_W-1:0]   ci;
  logic [mtp_pkg::WORD_W-1:0]   zr;
  logic [mtp_pkg::WORD_W-1:0]   zi;
  logic [mtp_pkg::WORD_W-1:0]   tr;
  logic [mtp_pkg::WORD_W-1:0]   ti;
  logic [mtp_pkg::K_W-1:0]      k;
  logic                         escaped;

  logic [mtp_pkg::CHAN_W-1:0]   out_red;
  logic [mtp_pkg::CHAN_W-1:0]   out_green;
  logic [mtp_pkg::CHAN_W-1:0]   out_blue;
  logic [mtp_pkg::STEPS_W-1:0]  out_steps;
  logic                         out_inside;

  logic [mtp_pkg::WORD_W-1:0]   c_re_next;
  logic [mtp_pkg::WORD_W-1:0]   c_im_next;
  logic [mtp_pkg::WORD_W-1:0]   mul0_b;
  logic [mtp_pkg::WORD_W-1:0]   mul0_res;
  logic [mtp_pkg::WORD_W-1:0]   mul1_res;
  logic                         mul0_done;
  logic                         mul1_done;
  logic [mtp_pkg::WORD_W-1:0]   mag_sq;
  logic [mtp_pkg::K_W-1:0]      k_m1;
  logic [RGB_W-1:0]             rgb;

  // floor(pos * 2^(FRAC_BITS+1-zoom) / TILE_SIZE), clamped to 5.5.
  function automatic logic [mtp_pkg::SCALED_W-1:0] scale_pos(
    input logic [mtp_pkg::PIX_W-1:0]  pix,
    input logic [mtp_pkg::TILE_W-1:0] tile,
    input logic [mtp_pkg::ZOOM_W-1:0] z
  );
    logic [mtp_pkg::POS_W-1:0]  pos;
    logic [mtp_pkg::WIDE_W-1:0] wide;
    pos  = (mtp_pkg::POS_W'(tile) << mtp_pkg::TILE_LOG2) + mtp_pkg::POS_W'(pix);
    wide = {pos, {mtp_pkg::UP_SH{1'b0}}} >> z;
    if (wide > mtp_pkg::WIDE_W'(mtp_pkg::SCALED_LIM)) begin
      return mtp_pkg::SCALED_LIM;
    end
    return mtp_pkg::SCALED_W'(wide);
  endfunction

  function automatic logic [mtp_pkg::WORD_W-1:0] offset_clamp(
    input logic [mtp_pkg::SCALED_W-1:0] s,
    input logic [mtp_pkg::WORD_W-1:0]   off
  );
    logic [mtp_pkg::WORD_W-1:0] c;
    c = mtp_pkg::WORD_W'(s) - off;
    if ($signed(c) > $signed(mtp_pkg::FOUR_FX)) begin
      c = mtp_pkg::FOUR_FX;
    end
    return c;
  endfunction

  // Hue to RGB at full saturation and value; result is {blue, green, red}.
  function automatic logic [RGB_W-1:0] hue_rgb(input logic [mtp_pkg::CHAN_W-1:0] h);
    logic [10:0]                six_h;
    logic [7:0]                 m;
    logic [2:0]                 sec;
    logic [15:0]                tp;
    logic [8:0]                 nm;
    logic [16:0]                qp;
    logic [mtp_pkg::CHAN_W-1:0] t;
    logic [mtp_pkg::CHAN_W-1:0] q;
    logic [mtp_pkg::CHAN_W-1:0] r;
    logic [mtp_pkg::CHAN_W-1:0] g;
    logic [mtp_pkg::CHAN_W-1:0] bl;
    six_h = 11'({h, 2'b00}) + 11'({h, 1'b0});
    m     = six_h[7:0];
    sec   = six_h[10:8];
    tp    = {m, 8'd0} - 16'(m);
    nm    = 9'd256 - 9'(m);
    qp    = {nm, 8'd0} - 17'(nm);
    t     = tp[15:8];
    q     = qp[15:8];
    unique case (sec)
      SEC_RED_YEL: begin r = CH_FULL; g = t;       bl = CH_ZERO; end
      SEC_YEL_GRN: begin r = q;       g = CH_FULL; bl = CH_ZERO; end
      SEC_GRN_CYN: begin r = CH_ZERO; g = CH_FULL; bl = t;       end
      SEC_CYN_BLU: begin r = CH_ZERO; g = q;       bl = CH_FULL; end
      SEC_BLU_MAG: begin r = t;       g = CH_ZERO; bl = CH_FULL; end
      default:     begin r = CH_FULL; g = CH_ZERO; bl = q;       end
    endcase
    return {bl, g, r};
  endfunction

  assign c_re_next = offset_clamp(s_re, mtp_pkg::OFFSET_RE);
  assign c_im_next = offset_clamp(s_im, mtp_pkg::OFFSET_IM);
  assign mul0_b    = cmd.start_p ? zi : zr;
  assign mag_sq    = tr + ti;
  assign k_m1      = k - mtp_pkg::K_W'(1);
  assign rgb       = hue_rgb(mtp_pkg::CHAN_W'(k_m1));

  mtp_fxmul u_mul0 (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start_sq | cmd.start_p),
    .a      (zr),
    .b      (mul0_b),
    .done   (mul0_done),
    .result (mul0_res)
  );

  mtp_fxmul u_mul1 (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start_sq),
    .a      (zi),
    .b      (zi),
    .done   (mul1_done),
    .result (mul1_res)
  );

  always_comb begin
    status.mul_done = mul0_done & (mul1_done | cmd.start_p | !cmd.cap_sq);
    status.escape   = mag_sq > mtp_pkg::FOUR_FX;
    status.k_zero   = (k == '0);
    status.k_last   = (k == mtp_pkg::K_W'(mtp_pkg::MAX_STEPS));
    status.out_free = !m_valid || m_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zoom    <= '0;
      tile_x  <= '0;
      tile_y  <= '0;
      m_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mtp_pkg::CFG_ZOOM:   zoom   <= cfg_data[mtp_pkg::ZOOM_W-1:0];
          mtp_pkg::CFG_TILE_X: tile_x <= cfg_data;
          mtp_pkg::CFG_TILE_Y: tile_y <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load_out) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_pix) begin
      pix_col <= s_data[mtp_pkg::PIX_W-1:0];
      pix_row <= s_data[mtp_pkg::IN_DATA_W-1:mtp_pkg::PIX_W];
    end
    if (cmd.scale) begin
      s_re <= scale_pos(pix_col, tile_x, zoom);
      s_im <= scale_pos(pix_row, tile_y, zoom);
    end
    if (cmd.offset) begin
      cr <= c_re_next;
      ci <= c_im_next;
      zr <= c_re_next;
      zi <= c_im_next;
      k  <= '0;
    end
    if (cmd.cap_sq) begin
      tr <= mul0_res;
      ti <= mul1_res;
    end
    // The product zr*zi still sits in the first multiplier's result register.
    if (cmd.update_z) begin
      zi <= (mul0_res << 1) + ci;
      zr <= tr - ti + cr;
      k  <= k + mtp_pkg::K_W'(1);
    end
    if (cmd.check) begin
      escaped <= status.escape;
    end
    if (cmd.load_out) begin
      out_red    <= escaped ? rgb[mtp_pkg::CHAN_W-1:0] : CH_ZERO;
      out_green  <= escaped ? rgb[2*mtp_pkg::CHAN_W-1:mtp_pkg::CHAN_W] : CH_ZERO;
      out_blue   <= escaped ? rgb[RGB_W-1:2*mtp_pkg::CHAN_W] : CH_ZERO;
      out_steps  <= mtp_pkg::STEPS_W'(k);
      out_inside <= !escaped;
    end
  end

  assign m_data = {{PAD_W{1'b0}}, out_steps, out_blue, out_green, out_red};
  assign m_user = out_inside;

  `MTP_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.load_out, status.out_free, "result overwritten")
  `MTP_ASSERT_IMP(a_mul_lockstep, clk, rst, mul1_done, mul0_done, "multipliers out of step")
  `MTP_ASSERT_IMP(a_step_bound, clk, rst, cmd.update_z, !status.k_last, "step count overrun")
  `MTP_ASSERT_NXT(a_sq_nonneg, clk, rst, cmd.cap_sq, !tr[mtp_pkg::WORD_W-1] && !ti[mtp_pkg::WORD_W-1], "negative square")

endmodule

>>> rtl/mtp_ctrl.sv
// Controller state machine that sequences one pixel through the datapath.
module mtp_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  mtp_pkg::mtp_status_t status,
  output mtp_pkg::mtp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    IDLE,
    SCALE,
    OFFSET,
    START_SQ,
    WAIT_SQ,
    START_P,
    WAIT_P,
    UPDATE,
    CHECK,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign s_ready = (state == IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      IDLE: begin
        if (s_valid) begin
          cmd.latch_pix = 1'b1;
          state_next    = SCALE;
        end
      end
      SCALE: begin
        cmd.scale  = 1'b1;
        state_next = OFFSET;
      end
      OFFSET: begin
        cmd.offset = 1'b1;
        state_next = START_SQ;
      end
      START_SQ: begin
        cmd.start_sq = 1'b1;
        state_next   = WAIT_SQ;
      end
      WAIT_SQ: begin
        // The squares of c itself come before the first step and need no escape test.
        if (status.mul_done) begin
          cmd.cap_sq = 1'b1;
          state_next = status.k_zero ? START_P : CHECK;
        end
      end
      START_P: begin
        cmd.start_p = 1'b1;
        state_next  = WAIT_P;
      end
      WAIT_P: begin
        if (status.mul_done) begin
          state_next = UPDATE;
        end
      end
      UPDATE: begin
        cmd.update_z = 1'b1;
        state_next   = START_SQ;
      end
      CHECK: begin
        cmd.check  = 1'b1;
        state_next = (status.escape || status.k_last) ? FINISH : START_P;
      end
      FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
